@@ rtl/rme_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
package rme_pkg;
    localparam int ATAB_LEN = 24;
    localparam int GUARD = 16;
    localparam int ACC_W = 24;
    localparam logic signed [ACC_W-1:0] ANG_90 = 24'sd2949120;
    localparam int VEC_W = 36;
    localparam int SQ_W = 32;
    localparam int SY_W = 16;

    function automatic logic signed [ACC_W-1:0] atab(input logic [4:0] i);
        logic signed [ACC_W-1:0] v;
        unique case (i)
            5'd0: v = 24'sd1474560;
            5'd1: v = 24'sd870484;
            5'd2: v = 24'sd459940;
            5'd3: v = 24'sd233473;
            5'd4: v = 24'sd117189;
            5'd5: v = 24'sd58652;
            5'd6: v = 24'sd29333;
            5'd7: v = 24'sd14667;
            5'd8: v = 24'sd7334;
            5'd9: v = 24'sd3667;
            5'd10: v = 24'sd1833;
            5'd11: v = 24'sd917;
            5'd12: v = 24'sd458;
            5'd13: v = 24'sd229;
            5'd14: v = 24'sd115;
            5'd15: v = 24'sd57;
            5'd16: v = 24'sd29;
            5'd17: v = 24'sd14;
            5'd18: v = 24'sd7;
            5'd19: v = 24'sd4;
            5'd20: v = 24'sd2;
            5'd21: v = 24'sd1;
            default: v = '0;
        endcase
        return v;
    endfunction

    typedef struct packed {
        logic signed [17:0] y;
        logic signed [17:0] x;
    } t_vec;

    typedef struct packed {
        t_vec roll;
        t_vec alt;
        t_vec yaw;
        logic signed [16:0] ny;
        logic [SQ_W-1:0] sq;
        logic [14:0] thr;
    } t_front;

    typedef struct packed {
        logic signed [15:0] roll;
        logic signed [14:0] pitch;
        logic signed [15:0] yaw;
        logic sing;
    } t_result;
endpackage
`default_nettype wire

@@ rtl/rme_isqrt.sv @@
`timescale 1ns / 1ps
`default_nettype none
// pipelined restoring square root, one result bit per stage
module rme_isqrt #(
    parameter int W = 32,
    parameter int PW = 1
) (
    input  wire logic            i_clk,
    input  wire logic            i_en,
    input  wire logic [W-1:0]    i_n,
    input  wire logic [PW-1:0]   i_pass,
    output logic [W/2-1:0]       o_root,
    output logic [PW-1:0]        o_pass
);
    localparam int N = W / 2;
    logic [W-1:0]   r_n [N+1];
    logic [W-1:0]   r_res [N+1];
    logic [PW-1:0]  r_pass [N+1];

    assign r_n[0] = i_n;
    assign r_res[0] = '0;
    assign r_pass[0] = i_pass;

    for (genvar s = 0; s < N; s++) begin : g_st
        logic [W-1:0] bitv;
        logic [W-1:0] t;
        logic [W-1:0] n_n;
        logic [W-1:0] n_res;
        always_comb begin
            bitv = {{(W-1){1'b0}}, 1'b1} << (W - 2 - 2 * s);
            t = r_res[s] + bitv;
            if (r_n[s] >= t) begin
                n_n = r_n[s] - t;
                n_res = (r_res[s] >> 1) + bitv;
            end else begin
                n_n = r_n[s];
                n_res = r_res[s] >> 1;
            end
        end
        logic [W-1:0] r_nq, r_rq;
        logic [PW-1:0] r_pq;
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_nq <= n_n;
                r_rq <= n_res;
                r_pq <= r_pass[s];
            end
        end
        assign r_n[s+1] = r_nq;
        assign r_res[s+1] = r_rq;
        assign r_pass[s+1] = r_pq;
    end

    assign o_root = r_res[N][N-1:0];
    assign o_pass = r_pass[N];
endmodule
`default_nettype wire

@@ rtl/rme_cordic.sv @@
`timescale 1ns / 1ps
`default_nettype none
// pipelined vectoring cordic atan2, one rotation per stage
module rme_cordic #(
    parameter int STEPS = 16,
    parameter int PW = 1
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_en,
    input  wire rme_pkg::t_vec        i_v,
    input  wire logic signed [15:0]   i_lim,
    input  wire logic [PW-1:0]        i_pass,
    output logic signed [15:0]        o_ang,
    output logic [PW-1:0]             o_pass
);
    localparam int VW = rme_pkg::VEC_W;
    localparam int AW = rme_pkg::ACC_W;

    logic signed [VW-1:0] r_x [STEPS+1];
    logic signed [VW-1:0] r_y [STEPS+1];
    logic signed [AW-1:0] r_a [STEPS+1];
    logic                 r_z [STEPS+1];
    logic signed [15:0]   r_l [STEPS+1];
    logic [PW-1:0]        r_p [STEPS+1];

    logic signed [VW-1:0] n_x0, n_y0;
    logic signed [AW-1:0] n_a0;
    always_comb begin
        n_x0 = VW'(i_v.x);
        n_y0 = VW'(i_v.y);
        n_a0 = '0;
        if (i_v.x < 0) begin
            if (i_v.y >= 0) begin
                n_x0 = VW'(i_v.y);
                n_y0 = -VW'(i_v.x);
                n_a0 = rme_pkg::ANG_90;
            end else begin
                n_x0 = -VW'(i_v.y);
                n_y0 = VW'(i_v.x);
                n_a0 = -rme_pkg::ANG_90;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_x[0] <= n_x0 <<< rme_pkg::GUARD;
            r_y[0] <= n_y0 <<< rme_pkg::GUARD;
            r_a[0] <= n_a0;
            r_z[0] <= (i_v.x == 0) && (i_v.y == 0);
            r_l[0] <= i_lim;
            r_p[0] <= i_pass;
        end
    end

    for (genvar s = 0; s < STEPS; s++) begin : g_st
        logic signed [AW-1:0] tab;
        assign tab = rme_pkg::atab(5'(s));
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                if (r_y[s] >= 0) begin
                    r_x[s+1] <= r_x[s] + (r_y[s] >>> s);
                    r_y[s+1] <= r_y[s] - (r_x[s] >>> s);
                    r_a[s+1] <= r_a[s] + tab;
                end else begin
                    r_x[s+1] <= r_x[s] - (r_y[s] >>> s);
                    r_y[s+1] <= r_y[s] + (r_x[s] >>> s);
                    r_a[s+1] <= r_a[s] - tab;
                end
                r_z[s+1] <= r_z[s];
                r_l[s+1] <= r_l[s];
                r_p[s+1] <= r_p[s];
            end
        end
    end

    logic signed [AW-1:0] rnd;
    logic signed [AW-1:0] lim_e;
    always_comb begin
        rnd = (r_a[STEPS] + AW'(128)) >>> 8;
        lim_e = AW'(r_l[STEPS]);
        if (r_z[STEPS]) o_ang = '0;
        else if (rnd > lim_e) o_ang = r_l[STEPS];
        else if (rnd < -lim_e) o_ang = -r_l[STEPS];
        else o_ang = rnd[15:0];
    end
    assign o_pass = r_p[STEPS];
endmodule
`default_nettype wire

@@ rtl/rme_front.sv @@
`timescale 1ns / 1ps
`default_nettype none
// front: squares the column and picks the operand pairs
module rme_front (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_valid,
    output logic                     o_ready,
    input  wire logic signed [15:0]  i_r00,
    input  wire logic signed [15:0]  i_r10,
    input  wire logic signed [15:0]  i_r20,
    input  wire logic signed [15:0]  i_r21,
    input  wire logic signed [15:0]  i_r22,
    input  wire logic signed [15:0]  i_r11,
    input  wire logic signed [15:0]  i_r12,
    input  wire logic [14:0]         i_thr,
    output logic                     o_valid,
    input  wire logic                i_ready,
    output rme_pkg::t_front          o_data
);
    logic r_valid;
    rme_pkg::t_front r_data;
    assign o_ready = !r_valid || i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
        if (o_ready && i_valid) begin
            r_data.sq <= 32'(i_r00) * 32'(i_r00) + 32'(i_r10) * 32'(i_r10);
            r_data.yaw <= '{y: 18'(i_r10), x: 18'(i_r00)};
            r_data.roll <= '{y: 18'(i_r21), x: 18'(i_r22)};
            r_data.alt <= '{y: -18'(i_r12), x: 18'(i_r11)};
            r_data.ny <= -17'(i_r20);
            r_data.thr <= i_thr;
        end
    end
    assign o_valid = r_valid;
    assign o_data = r_data;
endmodule
`default_nettype wire

@@ rtl/rotation_matrix_to_euler_unit.sv @@
// path: an accepted request passes the front register, the sqrt and cordic stages
// (16 sqrt stages, CORDIC_STEPS + 1 cordic stages) and the output register to the ports
// throughput: one request per cycle; a stalled output parks one result in a skid register
// and the back pipeline stops only while that register and its last stage are both full
// reset: synchronous active-low, clears valid flags, threshold returns to 1
`timescale 1ns / 1ps
`default_nettype none
module rotation_matrix_to_euler_unit #(
    parameter int CORDIC_STEPS = 16
) (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_cfg_valid,
    output logic                     o_cfg_ready,
    input  wire logic [14:0]         i_cfg_data,
    input  wire logic                i_valid,
    output logic                     o_ready,
    input  wire logic signed [15:0]  i_r00,
    input  wire logic signed [15:0]  i_r10,
    input  wire logic signed [15:0]  i_r20,
    input  wire logic signed [15:0]  i_r21,
    input  wire logic signed [15:0]  i_r22,
    input  wire logic signed [15:0]  i_r11,
    input  wire logic signed [15:0]  i_r12,
    output logic                     o_valid,
    input  wire logic                i_ready,
    output logic signed [15:0]       o_roll_deg,
    output logic signed [14:0]       o_pitch_deg,
    output logic signed [15:0]       o_yaw_deg,
    output logic                     o_singular
);
    localparam int SQL = rme_pkg::SQ_W / 2;
    localparam int LAT = SQL + CORDIC_STEPS + 1;

    logic [14:0] r_thr;
    assign o_cfg_ready = 1'b1;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_thr <= 15'd1;
        else if (i_cfg_valid) r_thr <= i_cfg_data;
    end

    logic f_valid, f_ready;
    rme_pkg::t_front f_data;

    rme_front u_front (
        .i_clk, .i_rst_n, .i_valid, .o_ready,
        .i_r00, .i_r10, .i_r20, .i_r21, .i_r22, .i_r11, .i_r12,
        .i_thr(r_thr), .o_valid(f_valid), .i_ready(f_ready), .o_data(f_data)
    );

    // back pipeline, stalls as a whole
    logic [LAT-1:0] r_vld;
    logic r_sk_full;
    logic adv;
    assign adv = !(r_vld[LAT-1] && r_sk_full);
    assign f_ready = adv;

    localparam int PW1 = 18 * 6 + 17 + 15;
    logic [PW1-1:0] s_in, s_out;
    logic [rme_pkg::SY_W-1:0] sy;
    assign s_in = {f_data.roll, f_data.alt, f_data.yaw, f_data.ny, f_data.thr};

    rme_isqrt #(.W(rme_pkg::SQ_W), .PW(PW1)) u_sqrt (
        .i_clk, .i_en(adv), .i_n(f_data.sq), .i_pass(s_in),
        .o_root(sy), .o_pass(s_out)
    );

    rme_pkg::t_vec roll_n, yaw_n, roll_s;
    logic signed [16:0] ny;
    logic [14:0] thr;
    logic sing;
    assign {roll_n, roll_s, yaw_n, ny, thr} = s_out;
    assign sing = {1'b0, sy} < {2'b0, thr};

    rme_pkg::t_vec vr, vp, vyw;
    assign vr = sing ? roll_s : roll_n;
    assign vp = '{y: 18'(ny), x: {2'b0, sy}};
    assign vyw = yaw_n;

    logic signed [15:0] a_r, a_p, a_y;
    logic pr, pp, py;
    rme_cordic #(.STEPS(CORDIC_STEPS), .PW(1)) u_cr (
        .i_clk, .i_en(adv), .i_v(vr), .i_lim(16'sd23040), .i_pass(sing),
        .o_ang(a_r), .o_pass(pr));
    rme_cordic #(.STEPS(CORDIC_STEPS), .PW(1)) u_cp (
        .i_clk, .i_en(adv), .i_v(vp), .i_lim(16'sd11520), .i_pass(1'b0),
        .o_ang(a_p), .o_pass(pp));
    rme_cordic #(.STEPS(CORDIC_STEPS), .PW(1)) u_cy (
        .i_clk, .i_en(adv), .i_v(vyw), .i_lim(16'sd23040), .i_pass(1'b0),
        .o_ang(a_y), .o_pass(py));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_vld <= '0;
        else if (adv) r_vld <= {r_vld[LAT-2:0], f_valid};
    end

    rme_pkg::t_result res, r_sk;
    assign res = '{roll: a_r, pitch: a_p[14:0], yaw: pr ? 16'sd0 : a_y, sing: pr};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_valid <= 1'b0;
            r_sk_full <= 1'b0;
        end else begin
            if (!o_valid || i_ready) begin
                if (r_sk_full) begin
                    o_valid <= 1'b1;
                    r_sk_full <= 1'b0;
                end else begin
                    o_valid <= r_vld[LAT-1];
                end
            end else if (r_vld[LAT-1] && !r_sk_full) begin
                r_sk_full <= 1'b1;
            end
        end
        if (!o_valid || i_ready) begin
            {o_roll_deg, o_pitch_deg, o_yaw_deg, o_singular} <= r_sk_full ? r_sk : res;
        end else if (r_vld[LAT-1] && !r_sk_full) begin
            r_sk <= res;
        end
    end

    logic unused;
    assign unused = ^{pp, py};
endmodule
`default_nettype wire

@@ rtl/rme_checker.sv @@
`timescale 1ns / 1ps
`default_nettype none
module rme_checker (
    input wire logic i_clk,
    input wire logic i_rst_n,
    input wire logic o_valid,
    input wire logic i_ready,
    input wire logic o_singular,
    input wire logic signed [15:0] o_yaw_deg,
    input wire logic signed [15:0] o_roll_deg,
    input wire logic signed [14:0] o_pitch_deg
);
    a_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_roll_deg)) else $error("stall");
    a_yaw: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_singular |-> o_yaw_deg == 16'sd0) else $error("yaw");
    a_roll: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_roll_deg <= 16'sd23040 && o_roll_deg >= -16'sd23040) else $error("roll");
    a_pitch: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_pitch_deg <= 15'sd11520 && o_pitch_deg >= -15'sd11520) else $error("pitch");
endmodule
bind rotation_matrix_to_euler_unit rme_checker u_chk (.*);
`default_nettype wire

@@ sim/euler_checker.sv @@
`timescale 1ns / 1ps
module euler_checker (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_cfg_valid,
    input  wire logic               i_cfg_ready,
    input  wire logic [14:0]        i_cfg_data,
    input  wire logic               i_valid,
    input  wire logic               i_ready_in,
    input  wire logic signed [15:0] i_r00,
    input  wire logic signed [15:0] i_r10,
    input  wire logic signed [15:0] i_r20,
    input  wire logic signed [15:0] i_r21,
    input  wire logic signed [15:0] i_r22,
    input  wire logic signed [15:0] i_r11,
    input  wire logic signed [15:0] i_r12,
    input  wire logic               i_out_valid,
    input  wire logic               i_out_ready,
    input  wire logic signed [15:0] i_roll,
    input  wire logic signed [14:0] i_pitch,
    input  wire logic signed [15:0] i_yaw,
    input  wire logic               i_sing,
    output int                      o_errors,
    output int                      o_pending
);
    localparam int STEPS = 16;
    localparam longint QUARTER_TURN = 2949120;

    rme_pkg::t_result angle_queue[$];
    logic [14:0] thr_model;

    function automatic longint turn_angle(input int k);
        longint tab[24] = '{1474560, 870484, 459940, 233473, 117189, 58652, 29333,
            14667, 7334, 3667, 1833, 917, 458, 229, 115, 57, 29, 14, 7, 4, 2, 1, 0, 0};
        return tab[k];
    endfunction

    function automatic longint vector_angle(input longint yv, input longint xv,
                                            input longint lim);
        longint acc, t, dx, dy, r;
        acc = 0;
        if (xv == 0 && yv == 0) return 0;
        if (xv < 0) begin
            if (yv >= 0) begin
                t = xv; xv = yv; yv = -t; acc = QUARTER_TURN;
            end else begin
                t = xv; xv = -yv; yv = t; acc = -QUARTER_TURN;
            end
        end
        xv = xv * 65536;
        yv = yv * 65536;
        for (int i = 0; i < STEPS; i++) begin
            dx = yv >>> i;
            dy = xv >>> i;
            if (yv >= 0) begin
                xv += dx; yv -= dy; acc += turn_angle(i);
            end else begin
                xv -= dx; yv += dy; acc -= turn_angle(i);
            end
        end
        r = (acc + 128) >>> 8;
        if (r > lim) r = lim;
        if (r < -lim) r = -lim;
        return r;
    endfunction

    function automatic longint root_floor(input longint n);
        longint s;
        s = 0;
        for (int b = 16; b >= 0; b--) begin
            if ((s + (longint'(1) << b)) * (s + (longint'(1) << b)) <= n)
                s += longint'(1) << b;
        end
        return s;
    endfunction

    function automatic rme_pkg::t_result euler_angles(input longint a00, input longint a10,
        input longint a20, input longint a21, input longint a22, input longint a11,
        input longint a12, input logic [14:0] thr);
        rme_pkg::t_result e;
        longint sy;
        sy = root_floor(a00 * a00 + a10 * a10);
        e.sing = sy < longint'(thr);
        e.pitch = 15'(vector_angle(-a20, sy, 11520));
        if (!e.sing) begin
            e.roll = 16'(vector_angle(a21, a22, 23040));
            e.yaw = 16'(vector_angle(a10, a00, 23040));
        end else begin
            e.roll = 16'(vector_angle(-a12, a11, 23040));
            e.yaw = '0;
        end
        return e;
    endfunction

    task automatic report_mismatch(input string what, input int got, input int want);
        $display("mismatch %s: got %0d expected %0d", what, got, want);
        o_errors++;
    endtask

    initial o_errors = 0;
    assign o_pending = angle_queue.size();

    always @(posedge i_clk) begin
        rme_pkg::t_result want;
        if (!i_rst_n) begin
            thr_model <= 15'd1;
        end else begin
            if (i_cfg_valid && i_cfg_ready) thr_model <= i_cfg_data;
            if (i_valid && i_ready_in)
                angle_queue = {angle_queue, euler_angles(i_r00, i_r10, i_r20, i_r21,
                    i_r22, i_r11, i_r12, thr_model)};
            if (i_out_valid && i_out_ready) begin
                if (angle_queue.size() == 0) begin
                    report_mismatch("unexpected result", 0, 0);
                end else begin
                    want = angle_queue.pop_front();
                    if (i_roll !== want.roll) report_mismatch("roll", i_roll, want.roll);
                    if (i_pitch !== want.pitch)
                        report_mismatch("pitch", i_pitch, want.pitch);
                    if (i_yaw !== want.yaw) report_mismatch("yaw", i_yaw, want.yaw);
                    if (i_sing !== want.sing)
                        report_mismatch("singular", i_sing, want.sing);
                end
            end
        end
    end
endmodule

@@ sim/testbench.sv @@
`timescale 1ns / 1ps
module testbench;
    logic i_clk = 0;
    logic i_rst_n = 0;
    logic cfg_valid = 0;
    logic [14:0] cfg_data = '0;
    logic req_valid = 0;
    logic signed [15:0] m00 = 0, m10 = 0, m20 = 0, m21 = 0, m22 = 0, m11 = 0, m12 = 0;
    logic res_ready = 0;
    logic cfg_ready, req_ready, res_valid, sing;
    logic signed [15:0] roll, yaw;
    logic signed [14:0] pitch;
    int errors, pending;
    int cycles = 0;
    bit stim_done = 0;

    rotation_matrix_to_euler_unit dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_cfg_valid(cfg_valid), .o_cfg_ready(cfg_ready), .i_cfg_data(cfg_data),
        .i_valid(req_valid), .o_ready(req_ready),
        .i_r00(m00), .i_r10(m10), .i_r20(m20), .i_r21(m21), .i_r22(m22),
        .i_r11(m11), .i_r12(m12),
        .o_valid(res_valid), .i_ready(res_ready),
        .o_roll_deg(roll), .o_pitch_deg(pitch), .o_yaw_deg(yaw), .o_singular(sing)
    );

    euler_checker u_check (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_cfg_valid(cfg_valid), .i_cfg_ready(cfg_ready), .i_cfg_data(cfg_data),
        .i_valid(req_valid), .i_ready_in(req_ready),
        .i_r00(m00), .i_r10(m10), .i_r20(m20), .i_r21(m21), .i_r22(m22),
        .i_r11(m11), .i_r12(m12),
        .i_out_valid(res_valid), .i_out_ready(res_ready),
        .i_roll(roll), .i_pitch(pitch), .i_yaw(yaw), .i_sing(sing),
        .o_errors(errors), .o_pending(pending)
    );

    always begin
        #5 i_clk = 1;
        #5 i_clk = 0;
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > 400000) begin
            $display("TEST FAILED");
            $finish;
        end
    end

    // result side stalls at random
    initial begin
        int gap;
        res_ready = 0;
        forever begin
            gap = ($urandom_range(0, 7) == 0) ? 0 : $urandom_range(0, 3);
            repeat (gap) @(negedge i_clk) res_ready = 0;
            @(negedge i_clk) res_ready = 1;
        end
    end

    task automatic write_threshold(input logic [14:0] v);
        @(negedge i_clk);
        cfg_valid = 1;
        cfg_data = v;
        @(posedge i_clk);
        while (!cfg_ready) @(posedge i_clk);
        @(negedge i_clk) cfg_valid = 0;
    endtask

    task automatic send_matrix(input logic [15:0] a00, a10, a20, a21, a22, a11, a12);
        int gap;
        gap = $urandom_range(0, 3);
        repeat (gap) @(negedge i_clk) req_valid = 0;
        @(negedge i_clk);
        req_valid = 1;
        m00 = a00; m10 = a10; m20 = a20; m21 = a21; m22 = a22; m11 = a11; m12 = a12;
        @(posedge i_clk);
        while (!req_ready) @(posedge i_clk);
    endtask

    task automatic drain_results();
        @(negedge i_clk) req_valid = 0;
        while (pending != 0) @(posedge i_clk);
        repeat (40) @(posedge i_clk);
    endtask

    task automatic send_rotation();
        real ax, ay, az, s;
        logic [15:0] e[9];
        ax = ($urandom_range(0, 65535) / 65535.0 - 0.5) * 6.2831853;
        az = ($urandom_range(0, 65535) / 65535.0 - 0.5) * 6.2831853;
        if ($urandom_range(0, 5) == 0)
            ay = (($urandom_range(0, 1) != 0) ? 1.0 : -1.0)
                 * (1.5707963 - $urandom_range(0, 2000) * 1.0e-6);
        else
            ay = ($urandom_range(0, 65535) / 65535.0 - 0.5) * 3.1415926;
        s = 16384.0;
        e[0] = 16'($rtoi(s * $cos(az) * $cos(ay)));
        e[1] = 16'($rtoi(s * $sin(az) * $cos(ay)));
        e[2] = 16'($rtoi(-s * $sin(ay)));
        e[3] = 16'($rtoi(s * $cos(ay) * $sin(ax)));
        e[4] = 16'($rtoi(s * $cos(ay) * $cos(ax)));
        e[5] = 16'($rtoi(s * ($sin(az) * $sin(ay) * $sin(ax) + $cos(az) * $cos(ax))));
        e[6] = 16'($rtoi(s * ($sin(az) * $sin(ay) * $cos(ax) - $cos(az) * $sin(ax))));
        send_matrix(e[0], e[1], e[2], e[3], e[4], e[5], e[6]);
    endtask

    task automatic send_noise();
        logic [15:0] v[7];
        foreach (v[k]) begin
            case ($urandom_range(0, 4))
                0: v[k] = 16'h8000;
                1: v[k] = 16'h7fff;
                2: v[k] = 16'($urandom_range(0, 8) - 4);
                default: v[k] = 16'($urandom);
            endcase
        end
        send_matrix(v[0], v[1], v[2], v[3], v[4], v[5], v[6]);
    endtask

    initial begin
        logic [14:0] thr_set[5] = '{15'd0, 15'd32767, 15'd200, 15'd4000, 15'd16384};
        repeat (11) @(posedge i_clk);
        @(negedge i_clk) i_rst_n = 1;

        // directed corners under the reset threshold
        send_matrix(16'h4000, 0, 0, 0, 16'h4000, 16'h4000, 0);
        send_matrix(0, 0, 0, 0, 0, 0, 0);
        send_matrix(0, 0, 16'hc000, 16'h4000, 0, 16'h4000, 0);
        send_matrix(0, 0, 16'h4000, 0, 0, 0, 16'hc000);
        send_matrix(16'h7fff, 16'h7fff, 16'h7fff, 16'h7fff, 16'h7fff, 16'h7fff, 16'h7fff);
        send_matrix(16'h8000, 16'h8000, 16'h8000, 16'h8000, 16'h8000, 16'h8000, 16'h8000);
        send_matrix(16'h8000, 0, 16'h7fff, 0, 16'h8000, 16'h8000, 16'h7fff);
        send_matrix(16'hc000, 0, 0, 0, 16'hc000, 0, 0);
        send_matrix(16'hc000, 16'hffff, 0, 16'hffff, 16'hc000, 0, 0);
        send_matrix(16'hffff, 0, 16'hffff, 1, 16'hffff, 16'hffff, 1);
        send_matrix(1, 0, 0, 0, 1, 0, 0);
        send_matrix(16'h0000, 16'h4000, 16'h0000, 16'h8000, 16'h0000, 0, 0);
        drain_results();

        for (int p = 0; p < 6; p++) begin
            if (p > 0) begin
                write_threshold((p <= 5) ? thr_set[p - 1] : 15'($urandom));
            end
            for (int n = 0; n < 300; n++) begin
                if ($urandom_range(0, 3) == 0) send_noise();
                else send_rotation();
            end
            drain_results();
        end
        write_threshold(15'($urandom_range(1, 32767)));
        for (int n = 0; n < 50; n++) send_rotation();
        drain_results();
        stim_done = 1;
    end

    initial begin
        wait (stim_done);
        if (errors == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end
endmodule
